### rtl/mspfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspfp_pkg
// Shared types, byte codes and the CRC-8/DVB-S2 byte update for the
// MSP v2 frame parser.
// ----------------------------------------------------------------------------
package mspfp_pkg;

  localparam logic [7:0] CRC_POLY    = 8'hD5;
  localparam logic [7:0] MARK_DOLLAR = 8'h24;
  localparam logic [7:0] MARK_X      = 8'h58;
  localparam logic [7:0] DIR_IN      = 8'h3E;
  localparam logic [7:0] DIR_OUT     = 8'h4D;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_CRC    = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  localparam logic [1:0] REG_WANTED_COMMAND = 2'd0;
  localparam logic [1:0] REG_FILTER_ENABLE  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd2;

  localparam logic [15:0] WANTED_COMMAND_RESET = 16'd182;
  localparam logic [15:0] MAX_PAYLOAD_RESET    = 16'd2048;

  // One result beat as it leaves the decoder.
  typedef struct packed {
    logic        has_checksum;
    logic [15:0] command;
    logic [1:0]  frame_status;
    logic        frame_end;
    logic        byte_valid;
    logic [7:0]  payload_byte;
  } res_t;

  // Live register values seen by the decoder.
  typedef struct packed {
    logic [15:0] wanted_command;
    logic        filter_enable;
    logic [15:0] max_payload;
  } cfg_t;

  // Feeds one byte into the CRC, MSB first.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/mspfp_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspfp_decode
// Frame state machine and running CRC; turns one accepted byte into at most
// one result beat in the same cycle.
// ----------------------------------------------------------------------------
module mspfp_decode
  import mspfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_accept,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_X       = 4'd1;
  localparam logic [3:0] PH_DIR     = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_CMD_LO  = 4'd4;
  localparam logic [3:0] PH_CMD_HI  = 4'd5;
  localparam logic [3:0] PH_LEN_LO  = 4'd6;
  localparam logic [3:0] PH_LEN_HI  = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CRC     = 4'd9;

  logic [3:0]  phase, phase_next;
  logic        inbound, inbound_next;
  logic [15:0] frame_command, frame_command_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_crc, running_crc_next;

  logic [7:0]  crc_upd;
  logic [15:0] seen_inc;
  logic [15:0] len_full;
  logic        passed;
  logic        rv;
  logic        r_byte_valid;
  logic        r_frame_end;
  logic [1:0]  r_status;
  logic [7:0]  r_payload;

  assign crc_upd  = crc_feed((phase == PH_FLAGS) ? 8'h00 : running_crc, rx_byte);
  assign seen_inc = bytes_seen + 16'd1;
  assign len_full = {rx_byte, payload_length[7:0]};
  assign passed   = !cfg.filter_enable || (frame_command == cfg.wanted_command);

  always_comb begin
    phase_next          = phase;
    inbound_next        = inbound;
    frame_command_next  = frame_command;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    running_crc_next    = running_crc;
    rv                  = 1'b0;
    r_byte_valid        = 1'b0;
    r_frame_end         = 1'b0;
    r_status            = STATUS_OK;
    r_payload           = 8'h00;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == MARK_DOLLAR) phase_next = PH_X;
      end
      PH_X: begin
        if (rx_byte == MARK_X) phase_next = PH_DIR;
        else if (rx_byte != MARK_DOLLAR) phase_next = PH_HUNT;
      end
      PH_DIR: begin
        if (rx_byte == DIR_IN || rx_byte == DIR_OUT) begin
          inbound_next = (rx_byte == DIR_IN);
          phase_next   = PH_FLAGS;
        end else begin
          phase_next = (rx_byte == MARK_DOLLAR) ? PH_X : PH_HUNT;
        end
      end
      PH_FLAGS: begin
        running_crc_next = crc_upd;
        phase_next       = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        running_crc_next   = crc_upd;
        frame_command_next = {8'h00, rx_byte};
        phase_next         = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        running_crc_next   = crc_upd;
        frame_command_next = {rx_byte, frame_command[7:0]};
        phase_next         = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        running_crc_next    = crc_upd;
        payload_length_next = {8'h00, rx_byte};
        phase_next          = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        running_crc_next    = crc_upd;
        payload_length_next = len_full;
        bytes_seen_next     = 16'd0;
        if (len_full > cfg.max_payload) begin
          phase_next  = PH_HUNT;
          rv          = 1'b1;
          r_frame_end = 1'b1;
          r_status    = STATUS_LENGTH;
        end else if (len_full == 16'd0) begin
          if (inbound) begin
            phase_next = PH_CRC;
          end else begin
            phase_next  = PH_HUNT;
            rv          = 1'b1;
            r_frame_end = 1'b1;
          end
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= payload_length) begin
          if (inbound) begin
            phase_next = PH_CRC;
          end else begin
            // An outbound frame closes on its last payload byte.
            phase_next  = PH_HUNT;
            rv          = 1'b1;
            r_frame_end = 1'b1;
          end
        end
        if (passed) begin
          rv           = 1'b1;
          r_byte_valid = 1'b1;
          r_payload    = rx_byte;
        end
      end
      PH_CRC: begin
        phase_next  = PH_HUNT;
        rv          = 1'b1;
        r_frame_end = 1'b1;
        if (payload_length != 16'd0 && rx_byte != running_crc) r_status = STATUS_CRC;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      inbound        <= 1'b0;
      frame_command  <= 16'd0;
      payload_length <= 16'd0;
      bytes_seen     <= 16'd0;
      running_crc    <= 8'h00;
    end else if (in_accept) begin
      phase          <= phase_next;
      inbound        <= inbound_next;
      frame_command  <= frame_command_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      running_crc    <= running_crc_next;
    end
  end

  assign res_valid          = in_accept && rv;
  assign res.payload_byte   = r_payload;
  assign res.byte_valid     = r_byte_valid;
  assign res.frame_end      = r_frame_end;
  assign res.frame_status   = r_status;
  assign res.command        = frame_command_next;
  assign res.has_checksum   = inbound_next;

  // Payload counting never runs past the announced size.
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_seen < payload_length))
    else $error("payload count reached the frame size inside the payload");

  // A size above the limit always ends the frame with a length status.
  a_len_error: assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_LEN_HI && len_full > cfg.max_payload)
      |-> (res_valid && res.frame_status == STATUS_LENGTH))
    else $error("oversize frame not closed with length status");

  // Status codes other than ok only appear on a closing beat.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.frame_status != STATUS_OK) |-> res.frame_end)
    else $error("error status on a beat that does not close a frame");

endmodule

### rtl/mspfp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspfp_out_buf
// Two-entry result buffer; keeps input acceptance going while a result
// waits on the downstream side.
// ----------------------------------------------------------------------------
module mspfp_out_buf
  import mspfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic has_space,
  output logic out_valid,
  input  logic out_ready,
  output res_t dout
);

  logic [1:0] count, count_next;
  res_t       head;
  res_t       tail;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign has_space  = (count != 2'd2);
  assign dout       = head;
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((count == 2'd0 && push) || (count == 2'd1 && pop && push)) begin
      head <= din;
    end else if (count == 2'd2 && pop) begin
      head <= tail;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      tail <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2 || pop))
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(head)))
    else $error("waiting result changed before it was taken");

endmodule

### rtl/msp_v2_frame_parser.sv
`timescale 1ns / 1ps
// Output: a result beat is registered in the result buffer before it is presented.
// Throughput: one byte per cycle while the result buffer has space; the state
// machine and bytewise CRC update finish within the cycle of acceptance, and a
// two-entry result buffer lets bytes keep flowing while one result waits on m_tready.
// Reset: synchronous, active-high rst returns the parser to hunting for '$',
// empties the result buffer and restores the register defaults.
// ----------------------------------------------------------------------------
// msp_v2_frame_parser
// MSP v2 frame parser with CRC-8/DVB-S2 check, command filter and size limit.
// ----------------------------------------------------------------------------
module msp_v2_frame_parser
  import mspfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] command
  output logic [3:0]  m_tuser,   // [0] byte_valid, [2:1] frame_status, [3] has_checksum
  output logic        m_tlast,   // frame_end
  // Register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  logic in_accept;
  logic has_space;
  logic res_valid;
  res_t res;
  res_t head;

  // Registers are always writable; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wanted_command <= WANTED_COMMAND_RESET;
      cfg.filter_enable  <= 1'b1;
      cfg.max_payload    <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WANTED_COMMAND: cfg.wanted_command <= cfg_data;
        REG_FILTER_ENABLE:  cfg.filter_enable  <= cfg_data[0];
        REG_MAX_PAYLOAD:    cfg.max_payload    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each byte makes at most one result, so one free slot is enough to take it.
  assign s_tready  = has_space;
  assign in_accept = s_tvalid && s_tready;

  mspfp_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mspfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .has_space (has_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (head)
  );

  assign m_tdata = {head.command, head.payload_byte};
  assign m_tuser = {head.has_checksum, head.frame_status, head.byte_valid};
  assign m_tlast = head.frame_end;

endmodule
